/* src/time_of_day_adjuster_macros.svh */
// Assertion macros for the time of day adjuster checker.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef TIME_OF_DAY_ADJUSTER_MACROS_SVH
`define TIME_OF_DAY_ADJUSTER_MACROS_SVH

// check at every clock edge outside reset
`define TDA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("time_of_day_adjuster: assertion failed");

// check at every clock edge, reset included
`define TDA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("time_of_day_adjuster: assertion failed during reset");

`endif

/* src/tda_pkg.sv */
// Package for the time of day adjuster: field widths, radix constants,
// operation codes and the request, result and pipeline item structs.
`default_nettype none

package tda_pkg;

  localparam int unsigned ModeW   = 4;
  localparam int unsigned AmountW = 31;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MilliW  = 10;

  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned MinPerHour = 60;
  localparam int unsigned HourPerDay = 24;

  localparam int unsigned MilliMax = MsPerSec - 1;
  localparam int unsigned SecMax   = SecPerMin - 1;
  localparam int unsigned MinMax   = MinPerHour - 1;
  localparam int unsigned HourMax  = HourPerDay - 1;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpSet = 2'd2,
    OpNop = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    UnitMilli = 2'd0,
    UnitSec   = 2'd1,
    UnitMin   = 2'd2,
    UnitHour  = 2'd3
  } unit_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [AmountW-1:0] amount;
  } tda_in_t;

  typedef struct packed {
    logic [HourW-1:0]  hour_now;
    logic [MinW-1:0]   minute_now;
    logic [SecW-1:0]   second_now;
    logic [MilliW-1:0] milli_now;
  } tda_out_t;

  typedef struct packed {
    op_e               op;
    unit_e             unit;
    logic              set_ok;
    logic [MilliW-1:0] set_val;
    logic [MilliW-1:0] d_milli;
    logic [SecW-1:0]   d_sec;
    logic [MinW-1:0]   d_min;
    logic [HourW-1:0]  d_hour;
  } tda_item_t;

endpackage

`default_nettype wire

/* src/tda_divstage.sv */
// Two-register digit extraction stage: divide by a constant through a
// reciprocal multiply, then correct once. Depends on tda_pkg.
`default_nettype none

module tda_divstage #(
  parameter int unsigned Divisor = tda_pkg::MsPerSec
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [tda_pkg::AmountW-1:0]   x_i,
  input  wire logic                          active_i,
  input  wire tda_pkg::tda_item_t            item_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [tda_pkg::AmountW-1:0]        quot_o,
  output logic [$clog2(Divisor)-1:0]         rem_o,
  output tda_pkg::tda_item_t                 item_o
);

  localparam int unsigned RecipW = 32;
  localparam int unsigned ProdW  = tda_pkg::AmountW + RecipW;
  localparam int unsigned RemW   = $clog2(Divisor);
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipW) / Divisor);

  logic                         a_valid_q;
  logic [tda_pkg::AmountW-1:0]  a_x_q;
  logic [ProdW-1:0]             a_prod_q;
  logic                         a_active_q;
  tda_pkg::tda_item_t           a_item_q;
  logic                         a_ready;
  logic                         a_load;

  logic                         b_valid_q;
  logic [tda_pkg::AmountW-1:0]  b_quot_q;
  logic [RemW-1:0]              b_rem_q;
  tda_pkg::tda_item_t           b_item_q;
  logic                         b_ready;
  logic                         b_load;

  logic [tda_pkg::AmountW-1:0]  q0;
  logic [tda_pkg::AmountW-1:0]  back;
  logic [tda_pkg::AmountW-1:0]  diff;
  logic [RemW:0]                r0;
  logic                         over;
  logic [tda_pkg::AmountW-1:0]  quot_d;
  logic [RemW-1:0]              rem_d;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign a_load  = valid_i && a_ready;
  assign b_load  = a_valid_q && b_ready;
  assign ready_o = a_ready;

  always_comb begin
    q0   = a_prod_q[ProdW-1 -: tda_pkg::AmountW];
    back = tda_pkg::AmountW'(q0 * Divisor);
    diff = a_x_q - back;
    r0   = diff[RemW:0];
    over = r0 >= (RemW+1)'(Divisor);
    if (!a_active_q) begin
      quot_d = a_x_q;
      rem_d  = '0;
    end else if (over) begin
      quot_d = q0 + tda_pkg::AmountW'(1);
      rem_d  = RemW'(r0 - (RemW+1)'(Divisor));
    end else begin
      quot_d = q0;
      rem_d  = r0[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_x_q      <= x_i;
      a_prod_q   <= ProdW'(x_i) * ProdW'(Recip);
      a_active_q <= active_i;
      a_item_q   <= item_i;
    end
    if (b_load) begin
      b_quot_q <= quot_d;
      b_rem_q  <= rem_d;
      b_item_q <= a_item_q;
    end
  end

  assign valid_o = b_valid_q;
  assign quot_o  = b_quot_q;
  assign rem_o   = b_rem_q;
  assign item_o  = b_item_q;

endmodule

`default_nettype wire

/* src/tda_clock.sv */
// Time register with mixed-radix add, subtract and field set; the time
// register is also the result register. Depends on tda_pkg.
`default_nettype none

module tda_clock (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire tda_pkg::tda_item_t item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tda_pkg::tda_out_t       out_data_o
);

  logic                        out_valid_q;
  logic [tda_pkg::HourW-1:0]   hour_q,  hour_d;
  logic [tda_pkg::MinW-1:0]    min_q,   min_d;
  logic [tda_pkg::SecW-1:0]    sec_q,   sec_d;
  logic [tda_pkg::MilliW-1:0]  milli_q, milli_d;
  logic                        load;

  logic [tda_pkg::MilliW:0]    ms_sum, ms_dif;
  logic [tda_pkg::SecW:0]      s_sum,  s_dif;
  logic [tda_pkg::MinW:0]      m_sum,  m_dif;
  logic [tda_pkg::HourW:0]     h_sum,  h_dif;
  logic                        c0, c1, c2, b0, b1, b2;
  logic [tda_pkg::MilliW-1:0]  ms_add, ms_sub;
  logic [tda_pkg::SecW-1:0]    s_add,  s_sub;
  logic [tda_pkg::MinW-1:0]    m_add,  m_sub;
  logic [tda_pkg::HourW-1:0]   h_add,  h_sub;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    ms_sum = (tda_pkg::MilliW+1)'(milli_q) + (tda_pkg::MilliW+1)'(item_i.d_milli);
    c0     = ms_sum >= (tda_pkg::MilliW+1)'(tda_pkg::MsPerSec);
    ms_add = c0 ? tda_pkg::MilliW'(ms_sum - (tda_pkg::MilliW+1)'(tda_pkg::MsPerSec))
                : ms_sum[tda_pkg::MilliW-1:0];
    s_sum  = (tda_pkg::SecW+1)'(sec_q) + (tda_pkg::SecW+1)'(item_i.d_sec)
           + (tda_pkg::SecW+1)'(c0);
    c1     = s_sum >= (tda_pkg::SecW+1)'(tda_pkg::SecPerMin);
    s_add  = c1 ? tda_pkg::SecW'(s_sum - (tda_pkg::SecW+1)'(tda_pkg::SecPerMin))
                : s_sum[tda_pkg::SecW-1:0];
    m_sum  = (tda_pkg::MinW+1)'(min_q) + (tda_pkg::MinW+1)'(item_i.d_min)
           + (tda_pkg::MinW+1)'(c1);
    c2     = m_sum >= (tda_pkg::MinW+1)'(tda_pkg::MinPerHour);
    m_add  = c2 ? tda_pkg::MinW'(m_sum - (tda_pkg::MinW+1)'(tda_pkg::MinPerHour))
                : m_sum[tda_pkg::MinW-1:0];
    h_sum  = (tda_pkg::HourW+1)'(hour_q) + (tda_pkg::HourW+1)'(item_i.d_hour)
           + (tda_pkg::HourW+1)'(c2);
    h_add  = (h_sum >= (tda_pkg::HourW+1)'(tda_pkg::HourPerDay))
           ? tda_pkg::HourW'(h_sum - (tda_pkg::HourW+1)'(tda_pkg::HourPerDay))
           : h_sum[tda_pkg::HourW-1:0];

    ms_dif = (tda_pkg::MilliW+1)'(milli_q) - (tda_pkg::MilliW+1)'(item_i.d_milli);
    b0     = ms_dif[tda_pkg::MilliW];
    ms_sub = b0 ? tda_pkg::MilliW'(ms_dif + (tda_pkg::MilliW+1)'(tda_pkg::MsPerSec))
                : ms_dif[tda_pkg::MilliW-1:0];
    s_dif  = (tda_pkg::SecW+1)'(sec_q) - (tda_pkg::SecW+1)'(item_i.d_sec)
           - (tda_pkg::SecW+1)'(b0);
    b1     = s_dif[tda_pkg::SecW];
    s_sub  = b1 ? tda_pkg::SecW'(s_dif + (tda_pkg::SecW+1)'(tda_pkg::SecPerMin))
                : s_dif[tda_pkg::SecW-1:0];
    m_dif  = (tda_pkg::MinW+1)'(min_q) - (tda_pkg::MinW+1)'(item_i.d_min)
           - (tda_pkg::MinW+1)'(b1);
    b2     = m_dif[tda_pkg::MinW];
    m_sub  = b2 ? tda_pkg::MinW'(m_dif + (tda_pkg::MinW+1)'(tda_pkg::MinPerHour))
                : m_dif[tda_pkg::MinW-1:0];
    h_dif  = (tda_pkg::HourW+1)'(hour_q) - (tda_pkg::HourW+1)'(item_i.d_hour)
           - (tda_pkg::HourW+1)'(b2);
    h_sub  = h_dif[tda_pkg::HourW]
           ? tda_pkg::HourW'(h_dif + (tda_pkg::HourW+1)'(tda_pkg::HourPerDay))
           : h_dif[tda_pkg::HourW-1:0];

    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    milli_d = milli_q;
    unique case (item_i.op)
      tda_pkg::OpAdd: begin
        hour_d  = h_add;
        min_d   = m_add;
        sec_d   = s_add;
        milli_d = ms_add;
      end
      tda_pkg::OpSub: begin
        hour_d  = h_sub;
        min_d   = m_sub;
        sec_d   = s_sub;
        milli_d = ms_sub;
      end
      tda_pkg::OpSet: begin
        if (item_i.set_ok) begin
          unique case (item_i.unit)
            tda_pkg::UnitMilli: milli_d = item_i.set_val;
            tda_pkg::UnitSec:   sec_d   = item_i.set_val[tda_pkg::SecW-1:0];
            tda_pkg::UnitMin:   min_d   = item_i.set_val[tda_pkg::MinW-1:0];
            tda_pkg::UnitHour:  hour_d  = item_i.set_val[tda_pkg::HourW-1:0];
            default:            milli_d = milli_q;
          endcase
        end
      end
      default: begin
        hour_d = hour_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      milli_q     <= '0;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (load) begin
        hour_q  <= hour_d;
        min_q   <= min_d;
        sec_q   <= sec_d;
        milli_q <= milli_d;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.hour_now   = hour_q;
  assign out_data_o.minute_now = min_q;
  assign out_data_o.second_now = sec_q;
  assign out_data_o.milli_now  = milli_q;

endmodule

`default_nettype wire

/* src/time_of_day_adjuster.sv */
// Time of day adjuster top level: request decode, four digit extraction
// stages and the time register. Depends on tda_pkg, tda_divstage, tda_clock.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request (mode, amount).
//   Output channel out_valid_o / out_stall_i returns the whole time after
//   that request, one result per request, in request order.
//   The amount is split into hour, minute, second and millisecond digits by
//   four two-register divide-by-constant stages, then the time register
//   applies the add, subtract or set with mixed-radix carry or borrow; a
//   no-op leaves the time as it is.
//   Throughput: one request per cycle; each stage and the time register
//   advance whenever the stage after them is empty or moving.
//   Reset: time goes to 00:00:00.000 and all stages empty.
//   Stall: while out_stall_i is high the result holds, requests keep filling
//   empty stages, and in_stall_o rises once the pipeline is full.
`default_nettype none

module time_of_day_adjuster (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tda_pkg::tda_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tda_pkg::tda_out_t     out_data_o
);

  localparam int unsigned MsRemW  = $clog2(tda_pkg::MsPerSec);
  localparam int unsigned SRemW   = $clog2(tda_pkg::SecPerMin);
  localparam int unsigned MRemW   = $clog2(tda_pkg::MinPerHour);
  localparam int unsigned HRemW   = $clog2(tda_pkg::HourPerDay);

  tda_pkg::tda_item_t            item0, item1, item2, item3, item4;
  tda_pkg::tda_item_t            ms_item, s_item, m_item, h_item;
  logic [tda_pkg::AmountW-1:0]   ms_quot, s_quot, m_quot;
  logic [MsRemW-1:0]             ms_rem;
  logic [SRemW-1:0]              s_rem;
  logic [MRemW-1:0]              m_rem;
  logic [HRemW-1:0]              h_rem;
  logic                          ms_valid, s_valid, m_valid, h_valid;
  logic                          ms_ready, s_ready, m_ready, h_ready, clk_ready;
  logic                          set_ok;

  always_comb begin
    unique case (tda_pkg::unit_e'(in_data_i.mode[1:0]))
      tda_pkg::UnitMilli: set_ok = in_data_i.amount <= tda_pkg::AmountW'(tda_pkg::MilliMax);
      tda_pkg::UnitSec:   set_ok = in_data_i.amount <= tda_pkg::AmountW'(tda_pkg::SecMax);
      tda_pkg::UnitMin:   set_ok = in_data_i.amount <= tda_pkg::AmountW'(tda_pkg::MinMax);
      tda_pkg::UnitHour:  set_ok = in_data_i.amount <= tda_pkg::AmountW'(tda_pkg::HourMax);
      default:            set_ok = 1'b0;
    endcase
    item0         = '0;
    item0.op      = tda_pkg::op_e'(in_data_i.mode[3:2]);
    item0.unit    = tda_pkg::unit_e'(in_data_i.mode[1:0]);
    item0.set_ok  = set_ok;
    item0.set_val = in_data_i.amount[tda_pkg::MilliW-1:0];
  end

  assign in_stall_o = !ms_ready;

  tda_divstage #(.Divisor(tda_pkg::MsPerSec)) u_ms_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (ms_ready),
    .x_i      (in_data_i.amount),
    .active_i (item0.unit == tda_pkg::UnitMilli),
    .item_i   (item0),
    .valid_o  (ms_valid),
    .ready_i  (s_ready),
    .quot_o   (ms_quot),
    .rem_o    (ms_rem),
    .item_o   (ms_item)
  );

  always_comb begin
    item1         = ms_item;
    item1.d_milli = ms_rem;
  end

  tda_divstage #(.Divisor(tda_pkg::SecPerMin)) u_s_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ms_valid),
    .ready_o  (s_ready),
    .x_i      (ms_quot),
    .active_i (item1.unit <= tda_pkg::UnitSec),
    .item_i   (item1),
    .valid_o  (s_valid),
    .ready_i  (m_ready),
    .quot_o   (s_quot),
    .rem_o    (s_rem),
    .item_o   (s_item)
  );

  always_comb begin
    item2       = s_item;
    item2.d_sec = s_rem;
  end

  tda_divstage #(.Divisor(tda_pkg::MinPerHour)) u_m_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_valid),
    .ready_o  (m_ready),
    .x_i      (s_quot),
    .active_i (item2.unit <= tda_pkg::UnitMin),
    .item_i   (item2),
    .valid_o  (m_valid),
    .ready_i  (h_ready),
    .quot_o   (m_quot),
    .rem_o    (m_rem),
    .item_o   (m_item)
  );

  always_comb begin
    item3       = m_item;
    item3.d_min = m_rem;
  end

  tda_divstage #(.Divisor(tda_pkg::HourPerDay)) u_h_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m_valid),
    .ready_o  (h_ready),
    .x_i      (m_quot),
    .active_i (1'b1),
    .item_i   (item3),
    .valid_o  (h_valid),
    .ready_i  (clk_ready),
    .quot_o   (),
    .rem_o    (h_rem),
    .item_o   (h_item)
  );

  always_comb begin
    item4        = h_item;
    item4.d_hour = h_rem;
  end

  tda_clock u_clock (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (h_valid),
    .ready_o     (clk_ready),
    .item_i      (item4),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* src/tda_checker.sv */
// Port-level checker for the time of day adjuster and its bind statement.
// Depends on tda_pkg and time_of_day_adjuster_macros.svh.
`default_nettype none
`include "time_of_day_adjuster_macros.svh"

module tda_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire tda_pkg::tda_in_t in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire tda_pkg::tda_out_t out_data_o
);

  `TDA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)
  `TDA_ASSERT(a_time_in_range, out_valid_o |-> (out_data_o.hour_now <= 5'd23) && (out_data_o.minute_now <= 6'd59) && (out_data_o.second_now <= 6'd59) && (out_data_o.milli_now <= 10'd999))
  `TDA_ASSERT(a_hold_on_stall, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `TDA_ASSERT(a_idle_time_stable, !out_valid_o ##1 !out_valid_o |-> $stable(out_data_o))
  `TDA_ASSERT(a_in_hold_on_stall, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))

endmodule

bind time_of_day_adjuster tda_checker u_tda_checker (.*);

`default_nettype wire
